FILE: hdl/gpthv_pkg.sv
// GPT header validator package: payload structs, register indexes, status codes,
// signature and CRC-32 constants, and the byte-wise CRC update.
// No dependencies.
package gpthv_pkg;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_BYTES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ENTRIES  = 1'd1;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_SIG   = 3'd1;
  localparam logic [2:0] ST_TOO_LARGE = 3'd2;
  localparam logic [2:0] ST_BAD_CRC   = 3'd3;
  localparam logic [2:0] ST_TOO_SHORT = 3'd4;

  // "EFI PART", byte 0 in the low lane
  localparam logic [63:0] SIG_WORD = 64'h5452_4150_2049_4645;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] computed_crc;
    logic [31:0] stored_crc;
    logic [63:0] entry_lba;
    logic [7:0]  entry_count;
  } out_t;

  // reflected CRC-32, one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

FILE: hdl/gpt_header_validator.sv
// GPT header validator top level: byte-stream field capture, CRC-32 and status.
// Depends on gpthv_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data) takes the raw header block one
//   byte per transfer, disk order, last_byte set on the block's final byte.
//   One result transfer (out_valid / out_stall / out_data) follows each
//   last byte; other bytes produce nothing.
//   Config port (cfg_we / cfg_index / cfg_data) writes the sector size limit
//   (index 0) and max_entries (index 1); write only while the block is idle.
// Throughput: one byte per cycle while in_stall is low. The CRC advances one byte per
//   cycle on the same terms; bytes 0-15 are also tracked in a running prefix CRC with per-byte
//   snapshots, so a header shorter than 16 bytes needs only a snapshot select.
// Result path: the last byte's summary is registered in b_r after the field-capture
//   stage, then the verdict in out_r after the status stage; out_valid rises when
//   out_r is loaded, and a stalled output register can hold the summary in b_r.
// Stall: the status stage and the output register form a two-entry pipe;
//   in_stall rises only when both hold a result and out_stall is high.
//   A stalled result holds steady.
// Reset (rst_n low, synchronous): byte counter and CRC restart, all captured
//   fields clear, no result pending, sector size 512, max_entries = 128.
// Bytes past MAX_BLOCK_BYTES are ignored; the byte count saturates there.
module gpt_header_validator #(
  parameter int MAX_BLOCK_BYTES = 4096
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  gpthv_pkg::in_t                      in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output gpthv_pkg::out_t                     out_data,
  input  logic                                cfg_we,
  input  logic [gpthv_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gpthv_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import gpthv_pkg::*;

  localparam int BIDX_W = $clog2(MAX_BLOCK_BYTES + 1);
  localparam logic [BIDX_W-1:0] BIDX_MAX = BIDX_W'(MAX_BLOCK_BYTES);

  // block summary handed from capture stage to status stage
  typedef struct packed {
    logic              sig_ok;
    logic [31:0]       crc;
    logic [31:0]       hdr_len;
    logic [BIDX_W-1:0] nbytes;
    logic [31:0]       stored;
    logic [63:0]       lba;
    logic [31:0]       count;
  } rec_t;

  // config
  logic [12:0] sector_bytes_r;
  logic [7:0]  max_entries_r;

  // capture state
  logic [BIDX_W-1:0] byte_index_r, byte_index_nxt;
  logic [31:0]       crc_r, crc_nxt;
  logic [31:0]       pre_crc_r, pre_crc_nxt;
  logic [31:0]       snap_r [15];
  logic              sig_ok_r, sig_ok_nxt;
  logic [31:0]       hdr_len_r, hdr_len_nxt;
  logic [31:0]       stored_r, stored_nxt;
  logic [63:0]       lba_r, lba_nxt;
  logic [31:0]       count_r, count_nxt;

  logic              b_valid_r;
  rec_t              b_r, rec;
  logic              out_valid_r;
  out_t              out_r, res;

  logic              acc, b_go;
  logic [BIDX_W-1:0] p;
  logic              active;
  logic [7:0]        b;
  logic [31:0]       pre_cur;
  logic [4:0]        p1, n_sel;
  logic [31:0]       sel_crc;
  logic [31:0]       crc_fin;

  // ---------------- flow control ----------------
  assign b_go     = b_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = b_valid_r && !b_go;
  assign acc      = in_valid && !in_stall;

  // ---------------- capture stage ----------------
  assign p       = byte_index_r;
  assign b       = in_data.data_byte;
  assign active  = p < BIDX_MAX;
  assign pre_cur = crc_byte(pre_crc_r, b);
  assign p1      = 5'(p[3:0]) + 5'd1;

  always_comb begin
    sig_ok_nxt     = sig_ok_r;
    hdr_len_nxt    = hdr_len_r;
    stored_nxt     = stored_r;
    lba_nxt        = lba_r;
    count_nxt      = count_r;
    pre_crc_nxt    = pre_crc_r;
    crc_nxt        = crc_r;
    byte_index_nxt = p;
    n_sel          = p1;
    sel_crc        = CRC_ONES;

    if (active) begin
      if (p < BIDX_W'(8) && b != SIG_WORD[{p[2:0], 3'b000} +: 8]) begin
        sig_ok_nxt = 1'b0;
      end
      if (p >= BIDX_W'(12) && p <= BIDX_W'(15)) begin
        hdr_len_nxt = hdr_len_r | (32'(b) << {p[1:0], 3'b000});
      end
      if (p >= BIDX_W'(16) && p <= BIDX_W'(19)) begin
        stored_nxt = stored_r | (32'(b) << {p[1:0], 3'b000});
      end
      if (p >= BIDX_W'(72) && p <= BIDX_W'(79)) begin
        lba_nxt = lba_r | (64'(b) << {p[2:0], 3'b000});
      end
      if (p >= BIDX_W'(80) && p <= BIDX_W'(83)) begin
        count_nxt = count_r | (32'(b) << {p[1:0], 3'b000});
      end
      if (p < BIDX_W'(16)) begin
        pre_crc_nxt = pre_cur;
      end
      byte_index_nxt = p + BIDX_W'(1);
    end

    // prefix CRC over min(bytes seen, header length) leading bytes
    if (hdr_len_nxt < 32'(p1)) begin
      n_sel = hdr_len_nxt[4:0];
    end
    if (n_sel == 5'd0) begin
      sel_crc = CRC_ONES;
    end else if (n_sel == p1) begin
      sel_crc = pre_cur;
    end else begin
      sel_crc = snap_r[4'(n_sel - 5'd1)];
    end

    if (active) begin
      if (p == BIDX_W'(15)) begin
        crc_nxt = sel_crc;
      end else if (p >= BIDX_W'(16) && 32'(p) < hdr_len_r) begin
        crc_nxt = crc_byte(crc_r, (p <= BIDX_W'(19)) ? 8'd0 : b);
      end
    end

    crc_fin = (byte_index_nxt < BIDX_W'(16)) ? sel_crc : crc_nxt;

    rec.sig_ok  = sig_ok_nxt && (byte_index_nxt >= BIDX_W'(8));
    rec.crc     = crc_fin ^ CRC_ONES;
    rec.hdr_len = hdr_len_nxt;
    rec.nbytes  = byte_index_nxt;
    rec.stored  = stored_nxt;
    rec.lba     = lba_nxt;
    rec.count   = count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_index_r <= '0;
      crc_r        <= CRC_ONES;
      pre_crc_r    <= CRC_ONES;
      sig_ok_r     <= 1'b1;
      hdr_len_r    <= '0;
      stored_r     <= '0;
      lba_r        <= '0;
      count_r      <= '0;
    end else if (acc) begin
      if (in_data.last_byte) begin
        // start over for the next block
        byte_index_r <= '0;
        crc_r        <= CRC_ONES;
        pre_crc_r    <= CRC_ONES;
        sig_ok_r     <= 1'b1;
        hdr_len_r    <= '0;
        stored_r     <= '0;
        lba_r        <= '0;
        count_r      <= '0;
      end else begin
        byte_index_r <= byte_index_nxt;
        crc_r        <= crc_nxt;
        pre_crc_r    <= pre_crc_nxt;
        sig_ok_r     <= sig_ok_nxt;
        hdr_len_r    <= hdr_len_nxt;
        stored_r     <= stored_nxt;
        lba_r        <= lba_nxt;
        count_r      <= count_nxt;
      end
    end
  end

  // snapshot of the prefix CRC after each of bytes 0-14
  always_ff @(posedge clk) begin
    if (acc && p < BIDX_W'(15)) begin
      snap_r[p[3:0]] <= pre_cur;
    end
  end

  // ---------------- status stage ----------------
  always_comb begin
    logic [7:0] cnt;
    cnt = (b_r.count < 32'(max_entries_r)) ? b_r.count[7:0] : max_entries_r;

    if (!b_r.sig_ok) begin
      res.status = ST_BAD_SIG;
    end else if (b_r.hdr_len > 32'(sector_bytes_r)) begin
      res.status = ST_TOO_LARGE;
    end else if (32'(b_r.nbytes) < b_r.hdr_len) begin
      res.status = ST_TOO_SHORT;
    end else if (b_r.crc != b_r.stored) begin
      res.status = ST_BAD_CRC;
    end else begin
      res.status = ST_OK;
    end

    res.computed_crc = (res.status == ST_OK || res.status == ST_BAD_CRC) ? b_r.crc : 32'd0;
    res.stored_crc   = b_r.stored;
    res.entry_lba    = (res.status == ST_OK) ? b_r.lba : 64'd0;
    res.entry_count  = (res.status == ST_OK) ? cnt : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (acc && in_data.last_byte) begin
        b_valid_r <= 1'b1;
      end else if (b_go) begin
        b_valid_r <= 1'b0;
      end
      if (b_go) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && in_data.last_byte) begin
      b_r <= rec;
    end
    if (b_go) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // ---------------- config ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sector_bytes_r <= 13'd512;
      max_entries_r  <= 8'd128;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SECTOR_BYTES: sector_bytes_r <= cfg_data;
        CFG_MAX_ENTRIES:  max_entries_r  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // ---------------- assertions ----------------
  a_last_makes_record: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_data.last_byte |=> b_valid_r)
    else $error("last byte transfer did not produce a pending result");

  a_fail_clears_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.status != ST_OK |->
      out_r.entry_lba == 64'd0 && out_r.entry_count == 8'd0)
    else $error("failed header reports entry fields");

  a_ok_crc_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.status == ST_OK |-> out_r.computed_crc == out_r.stored_crc)
    else $error("ok status with mismatched CRC");

  a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_data.last_byte |=> byte_index_r == '0 && crc_r == CRC_ONES)
    else $error("capture state not cleared after block end");

endmodule

FILE: tb/sv/gpt_header_validator_tb.sv
// Self-checking testbench for gpt_header_validator: streams GPT header blocks
// byte by byte, predicts each verdict in a local model and checks every result.
// Depends on gpthv_pkg and hdl/gpt_header_validator.sv.
module gpt_header_validator_tb;
  import gpthv_pkg::*;

  localparam int          MAX_BYTES = 4096;
  localparam int          LIMIT     = 600000;  // cycles; far beyond the slowest legal run
  localparam int          DRAIN_GAP = 4;       // two-stage result pipe plus margin
  localparam int          HOLD_LEN  = 300;     // long receiver hold-off, in cycles
  localparam int          BUF_LEN   = 4300;

  typedef enum int {HDR_GOOD, HDR_BAD_CRC, HDR_BAD_SIG} hdr_kind_t;

  logic            clk       = 1'b0;
  logic            rst_n     = 1'b0;
  logic            in_valid  = 1'b0;
  logic            in_stall;
  in_t             in_data   = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  out_t            out_data;
  logic            cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  gpt_header_validator #(
    .MAX_BLOCK_BYTES(MAX_BYTES)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Header-tracking model: mirrors the block's per-byte capture and CRC.
  // --------------------------------------------------------------------------
  logic [12:0] blk_size_q    = 13'd512;   // shadow of the sector size register
  logic [7:0]  max_ent_q     = 8'd128;    // shadow of max_entries

  int unsigned blk_idx       = 0;
  logic [31:0] crc_acc       = 32'hFFFF_FFFF;
  logic        sig_ok        = 1'b1;
  logic [31:0] hdr_len       = '0;
  logic [31:0] stored_crc_q  = '0;
  logic [63:0] lba_q         = '0;
  logic [31:0] count_q       = '0;
  logic [7:0]  head_bytes [16];

  out_t        expected_verdicts [$];
  in_t         pending_bytes [$];
  logic [7:0]  blk_buf [BUF_LEN];

  int          mismatches    = 0;
  int          items_queued  = 0;
  int unsigned cycles        = 0;

  bit          byte_taken    = 0;   // set on an input transfer, consumed by the driver
  bit          quiet_mode    = 0;   // no idling on either side
  bit          hold_request  = 0;
  int          gap_left      = 0;
  int          stall_left    = 0;
  int          hold_left     = 0;

  // reflected CRC-32, one byte, LSB first
  function automatic logic [31:0] crc32_step(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ 32'hEDB8_8320) : (c >> 1);
    end
    return c;
  endfunction

  // bytes 0-15 are replayed into the CRC once the header size is known
  task automatic replay_head(input int unsigned avail);
    int unsigned n;
    n = (avail < hdr_len) ? avail : hdr_len;
    if (n > 16) n = 16;
    for (int unsigned i = 0; i < n; i++) begin
      crc_acc = crc32_step(crc_acc, head_bytes[i]);
    end
  endtask

  task automatic clear_header();
    blk_idx      = 0;
    crc_acc      = 32'hFFFF_FFFF;
    sig_ok       = 1'b1;
    hdr_len      = '0;
    stored_crc_q = '0;
    lba_q        = '0;
    count_q      = '0;
    for (int i = 0; i < 16; i++) head_bytes[i] = '0;
  endtask

  task automatic track_byte(input in_t item);
    int unsigned p;
    logic [7:0]  b;
    logic [31:0] crc_final;
    logic [31:0] clamped;
    logic [2:0]  st;
    out_t        verdict;
    b = item.data_byte;
    // past MAX_BYTES the byte is dropped and the count holds
    if (blk_idx < MAX_BYTES) begin
      p = blk_idx;
      if (p < 8 && b != SIG_WORD[8*p +: 8]) sig_ok = 1'b0;
      if (p < 16) head_bytes[p] = b;
      if (p >= 12 && p <= 15) hdr_len = hdr_len | (32'(b) << (8 * (p - 12)));
      if (p >= 16 && p <= 19) stored_crc_q = stored_crc_q | (32'(b) << (8 * (p - 16)));
      if (p >= 72 && p <= 79) lba_q = lba_q | (64'(b) << (8 * (p - 72)));
      if (p >= 80 && p <= 83) count_q = count_q | (32'(b) << (8 * (p - 80)));
      if (p == 15) begin
        replay_head(16);
      end else if (p >= 16 && p < hdr_len) begin
        // the stored CRC field counts as zero
        crc_acc = crc32_step(crc_acc, (p <= 19) ? 8'd0 : b);
      end
      blk_idx = p + 1;
    end
    if (item.last_byte) begin
      // short block: head bytes not yet replayed
      if (blk_idx < 16) replay_head(blk_idx);
      if (blk_idx < 8) sig_ok = 1'b0;
      crc_final = ~crc_acc;
      if (!sig_ok)                           st = ST_BAD_SIG;
      else if (hdr_len > {19'd0, blk_size_q}) st = ST_TOO_LARGE;
      else if (blk_idx < hdr_len)            st = ST_TOO_SHORT;
      else if (crc_final != stored_crc_q)    st = ST_BAD_CRC;
      else                                   st = ST_OK;
      clamped = (count_q < {24'd0, max_ent_q}) ? count_q : {24'd0, max_ent_q};
      verdict.status       = st;
      verdict.computed_crc = (st == ST_OK || st == ST_BAD_CRC) ? crc_final : 32'd0;
      verdict.stored_crc   = stored_crc_q;
      verdict.entry_lba    = (st == ST_OK) ? lba_q : 64'd0;
      verdict.entry_count  = (st == ST_OK) ? clamped[7:0] : 8'd0;
      expected_verdicts.push_back(verdict);
      clear_header();
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus builders
  // --------------------------------------------------------------------------
  task automatic push_block(input int unsigned len);
    in_t item;
    for (int unsigned i = 0; i < len; i++) begin
      item.data_byte = blk_buf[i];
      item.last_byte = (i == len - 1);
      pending_bytes.push_back(item);
      items_queued++;
    end
  endtask

  task automatic queue_noise(input int unsigned max_len);
    int unsigned len;
    len = $urandom_range(1, max_len);
    for (int unsigned i = 0; i < len; i++) blk_buf[i] = 8'($urandom);
    push_block(len);
  endtask

  // builds a header block; CRC is computed over the bytes the block will see
  task automatic queue_header(input int unsigned hsize, input int unsigned len,
                              input hdr_kind_t kind);
    logic [31:0] c;
    logic [31:0] cnt;
    logic [63:0] lba;
    int unsigned n;
    int unsigned pos;
    for (int unsigned i = 0; i < len || i < 84; i++) blk_buf[i] = 8'($urandom);
    for (int i = 0; i < 8; i++) blk_buf[i] = SIG_WORD[8*i +: 8];
    for (int i = 0; i < 4; i++) blk_buf[12+i] = hsize[8*i +: 8];
    lba = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0:       cnt = 32'd128;
      1:       cnt = $urandom_range(0, 255);
      2:       cnt = $urandom;
      default: cnt = {24'd0, max_ent_q} + $urandom_range(0, 2) - 1;
    endcase
    for (int i = 0; i < 8; i++) blk_buf[72+i] = lba[8*i +: 8];
    for (int i = 0; i < 4; i++) blk_buf[80+i] = cnt[8*i +: 8];
    if (kind == HDR_BAD_SIG) begin
      pos = $urandom_range(0, 7);
      blk_buf[pos] = blk_buf[pos] ^ 8'($urandom_range(1, 255));
    end
    n = (hsize < len) ? hsize : len;
    if (n > MAX_BYTES) n = MAX_BYTES;
    c = 32'hFFFF_FFFF;
    for (int unsigned i = 0; i < n; i++) begin
      c = crc32_step(c, (i >= 16 && i <= 19) ? 8'd0 : blk_buf[i]);
    end
    c = ~c;
    if (kind == HDR_BAD_CRC) c = c ^ (32'd1 << $urandom_range(0, 31));
    for (int i = 0; i < 4; i++) blk_buf[16+i] = c[8*i +: 8];
    push_block(len);
  endtask

  task automatic queue_random_header();
    int unsigned hsize;
    int unsigned len;
    int          r;
    hdr_kind_t   kind;
    if ($urandom_range(0, 19) == 0) begin
      queue_noise(40);
    end else begin
      r = $urandom_range(0, 99);
      if (r < 40)      hsize = 92;
      else if (r < 75) hsize = $urandom_range(0, 120);
      else if (r < 80) hsize = {19'd0, blk_size_q} + $urandom_range(1, 8);
      else if (r < 85) hsize = $urandom;
      else             hsize = $urandom_range(93, 300);
      if (hsize > blk_size_q)               len = $urandom_range(1, 100);
      else if ($urandom_range(0, 99) < 85)  len = hsize + $urandom_range(0, 4);
      else                                  len = $urandom_range(1, hsize + 1);
      if (len == 0) len = 1;
      r = $urandom_range(0, 9);
      kind = (r == 0) ? HDR_BAD_SIG : (r == 1) ? HDR_BAD_CRC : HDR_GOOD;
      queue_header(hsize, len, kind);
    end
  endtask

  task automatic queue_random_until(input int target);
    while (items_queued < target) queue_random_header();
  endtask

  // --------------------------------------------------------------------------
  // Phase control
  // --------------------------------------------------------------------------
  task automatic wait_idle();
    while (pending_bytes.size() != 0 || in_valid || expected_verdicts.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx == CFG_SECTOR_BYTES) blk_size_q = val[12:0];
    else                         max_ent_q  = val[7:0];
  endtask

  task automatic set_config(input int unsigned bsize, input int unsigned maxe);
    wait_idle();
    write_reg(CFG_SECTOR_BYTES, CFG_DATA_W'(bsize));
    write_reg(CFG_MAX_ENTRIES, CFG_DATA_W'(maxe));
  endtask

  initial begin
    clear_header();
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // directed: single byte, short signature, 14-byte block with partial size
    blk_buf[0] = 8'hFF;
    push_block(1);
    for (int i = 0; i < 7; i++) blk_buf[i] = SIG_WORD[8*i +: 8];
    push_block(7);
    for (int i = 0; i < 14; i++) blk_buf[i] = (i < 8) ? SIG_WORD[8*i +: 8] : 8'h00;
    blk_buf[12] = 8'd12;
    push_block(14);

    // reset settings: full header, size limit edges around 512, tiny header
    queue_header(92, 92, HDR_GOOD);
    queue_header(512, 100, HDR_GOOD);
    queue_header(513, 40, HDR_GOOD);
    queue_header(15, 20, HDR_GOOD);
    queue_random_until(350);

    // sector size 4096, zero entry clamp, size limit edges at 4096
    set_config(4096, 0);
    queue_header(92, 96, HDR_GOOD);
    queue_header(4096, 60, HDR_GOOD);
    queue_header(4097, 60, HDR_GOOD);
    queue_random_until(items_queued + 250);

    // long receiver hold-off while short blocks keep arriving
    set_config(512, 1);
    hold_request = 1;
    for (int i = 0; i < 30; i++) queue_noise(12);
    queue_random_until(items_queued + 150);

    set_config($urandom_range(512, 4096), $urandom_range(1, 128));
    queue_random_until(items_queued + 150);

    // final stretch: back to reset values, no idling anywhere
    set_config(512, 128);
    quiet_mode = 1;
    queue_random_until(items_queued + 150);

    wait_idle();
    repeat (8) @(posedge clk);
    if (expected_verdicts.size() != 0) begin
      $error("results missing at end: %0d", expected_verdicts.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Input driver: holds a stalled byte, otherwise offers the next or idles.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !byte_taken) begin
      // stalled: payload stays put
    end else begin
      byte_taken = 0;
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_bytes.size() == 0) begin
        in_valid <= 1'b0;
      end else if (!quiet_mode && $urandom_range(0, 7) == 0) begin
        gap_left = $urandom_range(1, 4) - 1;
        in_valid <= 1'b0;
      end else begin
        in_valid <= 1'b1;
        in_data  <= pending_bytes.pop_front();
      end
    end
  end

  // Receiver stall: random bursts plus one long hold-off on request.
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left    = HOLD_LEN;
      hold_request = 0;
    end
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!quiet_mode && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 4) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Transfers at the rising edge: predict on input, compare on output.
  always @(posedge clk) begin
    out_t want;
    if (rst_n && in_valid && !in_stall) begin
      track_byte(in_data);
      byte_taken = 1;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected_verdicts.size() == 0) begin
        $error("result transfer with none expected: status %0d", out_data.status);
        mismatches++;
      end else begin
        want = expected_verdicts.pop_front();
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_data.status);
          mismatches++;
        end
        if (out_data.computed_crc !== want.computed_crc) begin
          $error("computed_crc: expected %h, actual %h",
                 want.computed_crc, out_data.computed_crc);
          mismatches++;
        end
        if (out_data.stored_crc !== want.stored_crc) begin
          $error("stored_crc: expected %h, actual %h", want.stored_crc, out_data.stored_crc);
          mismatches++;
        end
        if (out_data.entry_lba !== want.entry_lba) begin
          $error("entry_lba: expected %h, actual %h", want.entry_lba, out_data.entry_lba);
          mismatches++;
        end
        if (out_data.entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, actual %0d",
                 want.entry_count, out_data.entry_count);
          mismatches++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

endmodule
